// ===== design/can_bit_timing_logic_unit_assert.svh =====
// Assertion macros for the CAN bit timing block.
`ifndef CAN_BIT_TIMING_LOGIC_UNIT_ASSERT_SVH
`define CAN_BIT_TIMING_LOGIC_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define CBT_ASSERT_IMP(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("bit timing check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define CBT_ASSERT_NXT(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("bit timing check failed");

`endif

// ===== design/cbt_pkg.sv =====
// Shared types and constants for the CAN bit timing block.
package cbt_pkg;

  localparam int COUNT_BITS = 6;
  localparam int PE_MAX     = 63;

  // Segment codes
  typedef enum logic [2:0] {
    SEG_SYNC = 3'd0,
    SEG_ONE  = 3'd1,
    SEG_WIN1 = 3'd2,
    SEG_TWO  = 3'd3,
    SEG_WIN2 = 3'd4
  } seg_t;

  // Configuration register indexes
  localparam logic [2:0] REG_SEG1_QUANTA  = 3'd0;
  localparam logic [2:0] REG_SEG2_QUANTA  = 3'd1;
  localparam logic [2:0] REG_JUMP_WIDTH   = 3'd2;
  localparam logic [2:0] REG_TOTAL_QUANTA = 3'd3;

  typedef struct packed {
    logic [4:0] seg1_quanta;
    logic [3:0] seg2_quanta;
    logic [3:0] jump_width;
    logic [4:0] total_quanta;
  } cbt_cfg_t;

  typedef struct packed {
    seg_t                  next_seg;
    seg_t                  cur_seg;
    logic [COUNT_BITS-1:0] quanta_since_sync;
    logic [4:0]            seg1_count;
    logic [4:0]            seg2_count;
    logic signed [6:0]     phase_err;
    logic [3:0]            window_len;
    logic                  resync_allowed;
    logic                  write_flag;
    logic                  sample_flag;
  } cbt_state_t;

  localparam cbt_cfg_t CFG_RESET = '{
    seg1_quanta:  5'd8,
    seg2_quanta:  4'd7,
    jump_width:   4'd10,
    total_quanta: 5'd16
  };

  localparam cbt_state_t STATE_RESET = '{
    next_seg:          SEG_SYNC,
    cur_seg:           SEG_SYNC,
    quanta_since_sync: '0,
    seg1_count:        5'd0,
    seg2_count:        5'd0,
    phase_err:         7'sd0,
    window_len:        4'd0,
    resync_allowed:    1'b0,
    write_flag:        1'b0,
    sample_flag:       1'b0
  };

endpackage

// ===== design/cbt_step.sv =====
// Next-state logic for one time quantum of the bit timing state machine.
module cbt_step import cbt_pkg::*; (
  input  cbt_cfg_t   cfg,
  input  cbt_state_t st,
  input  logic       hard_sync_edge,
  input  logic       resync_edge,
  output cbt_state_t st_next
);

  logic [7:0] restart_sum;
  logic       restart;
  logic [3:0] win1_len;

  // SEG2 restart when jump width exceeds the negated phase error
  assign restart_sum = {4'b0000, cfg.jump_width} + {st.phase_err[6], st.phase_err};
  assign restart     = !restart_sum[7] && (restart_sum != 8'd0);

  // SEG1 window: phase error limited to 0..jump width
  always_comb begin
    if (st.phase_err[6]) begin
      win1_len = 4'd0;
    end else if ({3'b000, cfg.jump_width} < st.phase_err) begin
      win1_len = cfg.jump_width;
    end else begin
      win1_len = st.phase_err[3:0];
    end
  end

  always_comb begin
    cbt_state_t            m;
    cbt_state_t            n;
    logic [COUNT_BITS-1:0] qss_bump;
    logic [4:0]            seg1_inc;
    logic [4:0]            seg2_inc;
    logic [4:0]            seg1_new;
    logic [4:0]            seg2_new;
    logic [7:0]            pe_two;

    // Edge handling
    m             = st;
    m.write_flag  = 1'b0;
    m.sample_flag = 1'b0;
    if (hard_sync_edge) begin
      m.next_seg = SEG_SYNC;
    end else if (resync_edge && st.resync_allowed) begin
      if (st.cur_seg == SEG_ONE) begin
        m.window_len     = win1_len;
        m.next_seg       = SEG_WIN1;
        m.resync_allowed = 1'b0;
      end else if (st.cur_seg == SEG_TWO) begin
        if (restart) begin
          m.quanta_since_sync = '0;
          m.window_len        = 4'd0;
          m.phase_err         = 7'sd0;
          m.next_seg          = SEG_ONE;
        end else begin
          m.window_len = cfg.jump_width;
          m.next_seg   = SEG_WIN2;
        end
        m.resync_allowed = 1'b0;
      end
    end

    // Saturating counter steps
    qss_bump = (m.quanta_since_sync == {COUNT_BITS{1'b1}}) ? m.quanta_since_sync
                                                           : m.quanta_since_sync + 1'b1;
    seg1_inc = (m.seg1_count == 5'd31) ? m.seg1_count : m.seg1_count + 5'd1;
    seg2_inc = (m.seg2_count == 5'd31) ? m.seg2_count : m.seg2_count + 5'd1;
    seg1_new = 5'd0;
    seg2_new = 5'd0;
    pe_two   = 8'd0;

    // Segment advance
    n = m;
    unique case (m.next_seg)
      SEG_SYNC: begin
        n.write_flag        = 1'b1;
        n.resync_allowed    = 1'b1;
        n.quanta_since_sync = '0;
        n.window_len        = 4'd0;
        n.phase_err         = 7'sd0;
        n.cur_seg           = SEG_SYNC;
        n.next_seg          = SEG_ONE;
      end
      SEG_ONE: begin
        n.quanta_since_sync = qss_bump;
        if (m.cur_seg == SEG_SYNC) begin
          seg1_new = 5'd0;
        end else if (m.cur_seg == SEG_ONE) begin
          seg1_new = seg1_inc;
        end else begin
          n.write_flag = 1'b1;
          seg1_new     = 5'd0;
        end
        n.seg1_count = seg1_new;
        n.cur_seg    = SEG_ONE;
        if ({{(16-COUNT_BITS){1'b0}}, qss_bump} > 16'(PE_MAX)) begin
          n.phase_err = 7'(PE_MAX);
        end else begin
          n.phase_err = 7'(qss_bump);
        end
        if (({1'b0, seg1_new} + 6'd1) >= {1'b0, cfg.seg1_quanta}) begin
          n.next_seg = SEG_TWO;
        end
      end
      SEG_WIN1: begin
        n.cur_seg           = SEG_WIN1;
        n.quanta_since_sync = qss_bump;
        n.seg1_count        = seg1_inc;
        if (({2'b00, seg1_inc} + 7'd1) >=
            ({2'b00, cfg.seg1_quanta} + {3'b000, m.window_len})) begin
          n.next_seg = SEG_TWO;
        end
      end
      SEG_TWO: begin
        n.quanta_since_sync = qss_bump;
        if (m.cur_seg == SEG_ONE || m.cur_seg == SEG_WIN1) begin
          seg2_new      = 5'd0;
          n.sample_flag = 1'b1;
        end else begin
          seg2_new = seg2_inc;
        end
        n.seg2_count = seg2_new;
        n.cur_seg    = SEG_TWO;
        // Range stays within -30..63, so no clamp is needed
        pe_two = {3'b000, seg2_new} + 8'd1 + {3'b000, cfg.seg1_quanta}
                 - {3'b000, cfg.total_quanta};
        n.phase_err = pe_two[6:0];
        if (({1'b0, seg2_new} + 6'd1) >= {2'b00, cfg.seg2_quanta}) begin
          n.next_seg = SEG_SYNC;
        end
      end
      default: begin
        // SEG2 shortening window
        n.cur_seg           = SEG_WIN2;
        n.quanta_since_sync = qss_bump;
        n.seg2_count        = seg2_inc;
        if (({1'b0, seg2_inc} + 6'd1 + {2'b00, m.window_len}) >=
            {2'b00, cfg.seg2_quanta}) begin
          n.next_seg = SEG_SYNC;
        end
      end
    endcase

    st_next = n;
  end

endmodule

// ===== design/can_bit_timing_logic_unit.sv =====
// CAN bit timing unit: quantum-tick segment state machine with hard sync and resync.
// Result words are registered: each goes to the output register, or to the skid entry while that one is full.
// Throughput: one word per cycle; input is held off only while both output entries are full.
// The state update for a tick is a single pass through the next-state logic.
// Reset (synchronous, active high): registers to their defaults, state to SYNC, stage empty.
module can_bit_timing_logic_unit import cbt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] tick, [1] hard_sync_edge, [2] resync_edge
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [0] write_point, [1] sample_now, [4:2] segment,
                                      // [11:5] phase_err
  // Configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [4:0]  cfg_data
);

  cbt_cfg_t   cfg;
  cbt_state_t st;
  cbt_state_t st_next;
  cbt_state_t res;
  logic       tick;
  logic       accept;
  logic       pop;
  logic [15:0] res_word;
  logic        out_valid;
  logic [15:0] out_data;
  logic        skid_valid;
  logic [15:0] skid_data;

  assign tick          = s_axis_tdata[0];
  assign s_axis_tready = !skid_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pop           = out_valid && m_axis_tready;
  assign cfg_ready     = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SEG1_QUANTA:  cfg.seg1_quanta  <= cfg_data;
        REG_SEG2_QUANTA:  cfg.seg2_quanta  <= cfg_data[3:0];
        REG_JUMP_WIDTH:   cfg.jump_width   <= cfg_data[3:0];
        REG_TOTAL_QUANTA: cfg.total_quanta <= cfg_data;
        default: ;
      endcase
    end
  end

  cbt_step u_step (
    .cfg            (cfg),
    .st             (st),
    .hard_sync_edge (s_axis_tdata[1]),
    .resync_edge    (s_axis_tdata[2]),
    .st_next        (st_next)
  );

  // State advances only on an accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (accept && tick) begin
      st <= st_next;
    end
  end

  // Result word from the state after this word
  assign res      = tick ? st_next : st;
  assign res_word = {4'b0000, res.phase_err, res.cur_seg, res.sample_flag, res.write_flag};

  // Two-entry output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else if (accept) begin
        out_data <= res_word;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid) begin
        out_data  <= res_word;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= res_word;
        skid_valid <= 1'b1;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  `include "can_bit_timing_logic_unit_assert.svh"

  // Skid entry only holds a word behind the output register
  `CBT_ASSERT_IMP(a_skid_behind_out, skid_valid, out_valid)
  // A hard sync on an accepted tick lands in SYNC
  `CBT_ASSERT_NXT(a_hard_sync, accept && tick && s_axis_tdata[1], st.cur_seg == SEG_SYNC)
  // Sample pulse only on the first quantum of SEG2
  `CBT_ASSERT_IMP(a_sample_in_seg2, st.sample_flag, st.cur_seg == SEG_TWO)
  // Write pulse only in SYNC or on a restart into SEG1
  `CBT_ASSERT_IMP(a_write_seg, st.write_flag, st.cur_seg == SEG_SYNC || st.cur_seg == SEG_ONE)

endmodule

// ===== tb/tb_can_bit_timing_logic_unit.sv =====
// Self-checking testbench for the CAN bit timing unit: stream stimulus against a timing predictor.
`timescale 1ns / 1ps

module tb_can_bit_timing_logic_unit;
  import cbt_pkg::*;

  localparam int TQ_MAX = (1 << COUNT_BITS) - 1;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;    // [0] tick, [1] hard_sync_edge, [2] resync_edge
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [0] write_point, [1] sample_now, [4:2] segment,
                                     // [11:5] phase_err
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [4:0]  cfg_data = '0;

  can_bit_timing_logic_unit DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct packed {
    logic              wp;
    logic              sp;
    seg_t              seg;
    logic signed [6:0] pe;
  } timing_out_t;

  timing_out_t pending_timing[$];
  int          errors = 0;
  int          burst_left = 0;

  // Predicted block state and registers
  cbt_cfg_t timing_regs;
  seg_t     nxt_seg, cur_seg;
  int       tq_count, s1_cnt, s2_cnt, pe_q, win;
  bit       resync_ok, wp_q, sp_q;

  function automatic int clampi(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic reset_model();
    timing_regs = CFG_RESET;
    nxt_seg = SEG_SYNC;
    cur_seg = SEG_SYNC;
    tq_count = 0;
    s1_cnt = 0;
    s2_cnt = 0;
    pe_q = 0;
    win = 0;
    resync_ok = 0;
    wp_q = 0;
    sp_q = 0;
  endtask

  // One quantum of the segment state machine
  task automatic advance_bit_timing(bit hard, bit resync);
    int jw, s1q, s2q, tot;
    jw = int'(timing_regs.jump_width);
    s1q = int'(timing_regs.seg1_quanta);
    s2q = int'(timing_regs.seg2_quanta);
    tot = int'(timing_regs.total_quanta);
    wp_q = 0;
    sp_q = 0;

    // edges: hard sync wins, resync only once per bit
    if (hard) begin
      nxt_seg = SEG_SYNC;
    end else if (resync && resync_ok) begin
      if (cur_seg == SEG_ONE) begin
        win = clampi(clampi(pe_q, -64, jw), 0, 15);
        nxt_seg = SEG_WIN1;
        resync_ok = 0;
      end else if (cur_seg == SEG_TWO) begin
        if (jw > -pe_q) begin
          tq_count = 0;
          win = 0;
          pe_q = 0;
          nxt_seg = SEG_ONE;
        end else begin
          win = clampi(jw, 0, 15);
          nxt_seg = SEG_WIN2;
        end
        resync_ok = 0;
      end
    end

    case (nxt_seg)
      SEG_SYNC: begin
        wp_q = 1;
        resync_ok = 1;
        tq_count = 0;
        win = 0;
        pe_q = 0;
        cur_seg = SEG_SYNC;
        nxt_seg = SEG_ONE;
      end
      SEG_ONE: begin
        if (tq_count < TQ_MAX) tq_count++;
        if (cur_seg == SEG_SYNC) begin
          s1_cnt = 0;
        end else if (cur_seg == SEG_ONE) begin
          if (s1_cnt < 31) s1_cnt++;
        end else begin
          // restart after a resync in segment two
          wp_q = 1;
          s1_cnt = 0;
        end
        cur_seg = SEG_ONE;
        pe_q = clampi(tq_count, -64, 63);
        if (s1_cnt >= s1q - 1) nxt_seg = SEG_TWO;
      end
      SEG_WIN1: begin
        cur_seg = SEG_WIN1;
        if (tq_count < TQ_MAX) tq_count++;
        if (s1_cnt < 31) s1_cnt++;
        if (s1_cnt >= s1q - 1 + win) nxt_seg = SEG_TWO;
      end
      SEG_TWO: begin
        if (tq_count < TQ_MAX) tq_count++;
        if (cur_seg == SEG_ONE || cur_seg == SEG_WIN1) begin
          s2_cnt = 0;
          sp_q = 1;
        end else if (s2_cnt < 31) begin
          s2_cnt++;
        end
        cur_seg = SEG_TWO;
        pe_q = clampi(s2_cnt + 1 + s1q - tot, -64, 63);
        if (s2_cnt >= s2q - 1) nxt_seg = SEG_SYNC;
      end
      default: begin
        cur_seg = SEG_WIN2;
        if (tq_count < TQ_MAX) tq_count++;
        if (s2_cnt < 31) s2_cnt++;
        if (s2_cnt >= s2q - 1 - win) nxt_seg = SEG_SYNC;
      end
    endcase
  endtask

  // Input side: predict on every accepted word
  always @(posedge clk) begin : predict_input
    timing_out_t exp_word;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      if (s_axis_tdata[0]) advance_bit_timing(s_axis_tdata[1], s_axis_tdata[2]);
      exp_word.wp = wp_q;
      exp_word.sp = sp_q;
      exp_word.seg = cur_seg;
      exp_word.pe = pe_q[6:0];
      pending_timing.push_back(exp_word);
    end
  end

  // Register writes as the block sees them
  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SEG1_QUANTA:  timing_regs.seg1_quanta = cfg_data;
        REG_SEG2_QUANTA:  timing_regs.seg2_quanta = cfg_data[3:0];
        REG_JUMP_WIDTH:   timing_regs.jump_width = cfg_data[3:0];
        REG_TOTAL_QUANTA: timing_regs.total_quanta = cfg_data;
        default: ;
      endcase
    end
  end

  function automatic void check_field(string name, logic signed [7:0] want,
                                      logic signed [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Output side: compare each result word with the oldest prediction
  always @(posedge clk) begin : check_output
    timing_out_t want, got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.wp = m_axis_tdata[0];
      got.sp = m_axis_tdata[1];
      got.seg = seg_t'(m_axis_tdata[4:2]);
      got.pe = m_axis_tdata[11:5];
      if (pending_timing.size() == 0) begin
        $display("%0t: unexpected result word, expected none actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = pending_timing.pop_front();
        check_field("write_point", 8'(want.wp), 8'(got.wp));
        check_field("sample_now", 8'(want.sp), 8'(got.sp));
        check_field("segment", 8'(want.seg), 8'(got.seg));
        check_field("phase_err", 8'(want.pe), 8'(got.pe));
      end
    end
  end

  // Receiver stall pattern: a random mode, redrawn each time a random countdown runs out
  int stall_mode = 0;
  int stall_left = 0;
  int cyc = 0;
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= (cyc % 7 < 4);
    endcase
  end

  // Send one word; the sender works in bursts with random gaps between them
  task automatic send_word(bit t, bit h, bit r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'b0, r, h, t};
    do @(posedge clk); while (!s_axis_tready);
    burst_left--;
  endtask

  // Hold the input until every predicted word has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_timing.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [4:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Reprogram all timing registers on an idle block, plus one unmapped index
  task automatic set_timing(logic [4:0] s1, logic [4:0] s2, logic [4:0] jw, logic [4:0] tot);
    logic [2:0] spare;
    spare = REG_TOTAL_QUANTA + 3'($urandom_range(1, 4));
    drain_results();
    cfg_write(REG_SEG1_QUANTA, s1);
    cfg_write(REG_SEG2_QUANTA, s2);
    cfg_write(REG_JUMP_WIDTH, jw);
    cfg_write(REG_TOTAL_QUANTA, tot);
    cfg_write(spare, 5'($urandom_range(0, 31)));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Reset defaults: idle words, resync outside segment one, second resync, both edges
  task automatic test_directed_edges();
    send_word(1, 1, 0);
    send_word(0, 1, 1);
    send_word(0, 0, 0);
    send_word(1, 0, 1);
    send_word(1, 0, 1);
    send_word(1, 0, 1);
    send_word(1, 1, 1);
  endtask

  // Segment two resync: shortening with a small jump width, restart with a large one
  task automatic test_directed_seg2();
    set_timing(5'd2, 5'd8, 5'd1, 5'd25);
    send_word(1, 1, 0);
    repeat (3) send_word(1, 0, 0);
    send_word(1, 0, 1);
    repeat (6) send_word(1, 0, 0);
    set_timing(5'd2, 5'd3, 5'd15, 5'd4);
    send_word(1, 1, 0);
    repeat (3) send_word(1, 0, 0);
    send_word(1, 0, 1);
    send_word(1, 0, 0);
  endtask

  // Random ticks over several register settings, extremes and out-of-range ones included
  task automatic test_random_timing();
    bit t, h, r, noisy;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_timing(5'd8, 5'd7, 5'd10, 5'd16);
        1: set_timing(5'd2, 5'd1, 5'd1, 5'd4);
        2: set_timing(5'd16, 5'd8, 5'd15, 5'd25);
        3: set_timing(5'd2, 5'd8, 5'd1, 5'd25);
        4: set_timing(5'd31, 5'd15, 5'd15, 5'd0);
        5: set_timing(5'd0, 5'd0, 5'd0, 5'd31);
        6: set_timing(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                      5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
        default: set_timing(5'($urandom_range(2, 16)), 5'($urandom_range(1, 8)),
                            5'($urandom_range(1, 15)), 5'($urandom_range(4, 25)));
      endcase
      for (int i = 0; i < 175; i++) begin
        // one full pause mid-phase
        if (ph == 3 && i == 80) drain_results();
        noisy = (ph == 6) || ($urandom_range(0, 19) == 0);
        if (noisy) begin
          t = 1'($urandom_range(0, 1));
          h = 1'($urandom_range(0, 1));
          r = 1'($urandom_range(0, 1));
        end else begin
          t = ($urandom_range(0, 9) != 0);
          h = t ? ($urandom_range(0, 59) == 0) : 1'($urandom_range(0, 1));
          r = t ? ($urandom_range(0, 5) == 0) : 1'($urandom_range(0, 1));
        end
        send_word(t, h, r);
      end
    end
  endtask

  initial begin
    reset_model();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_edges();
    test_directed_seg2();
    test_random_timing();
    drain_results();
    repeat (5) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/cbt_pkg.sv
design/cbt_step.sv
design/can_bit_timing_logic_unit.sv
tb/tb_can_bit_timing_logic_unit.sv
